/* src/s4rf_pkg.sv */
`default_nettype none

package s4rf_pkg;

  // Request framing
  localparam int MAX_REQUEST = 4096;
  localparam int POS_W       = $clog2(MAX_REQUEST + 1);
  localparam int HEADER_LEN  = 8;

  // Permit table
  localparam int NUM_RULES   = 6;
  localparam int RULE_W      = 38;

  // Command codes
  localparam logic [7:0] CMD_CONNECT = 8'd1;
  localparam logic [7:0] CMD_BIND    = 8'd2;

  // Reply status codes
  localparam logic [7:0] REPLY_GRANT  = 8'd90;
  localparam logic [7:0] REPLY_REJECT = 8'd91;

  // Reply framing
  localparam int REPLY_BEATS = 8;
  localparam int BEAT_W      = $clog2(REPLY_BEATS);

  // Configuration register map
  localparam int              CFG_IDX_W     = 3;
  localparam int              CFG_DATA_W    = RULE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BIND_PORT = 3'd0;
  localparam int              CFG_RULE_BASE = 1;

  // One permit rule, packed as written through the configuration port
  typedef struct packed {
    logic        valid;
    logic        kind_bind;
    logic [3:0]  wild;
    logic [31:0] addr;
  } rule_t;

  // Everything needed to serialise one reply
  typedef struct packed {
    logic        granted;
    logic        is4a;
    logic        is_bind;
    logic [15:0] port;
    logic [31:0] addr;
  } reply_t;

endpackage

`default_nettype wire

/* src/s4rf_rule_match.sv */
`default_nettype none

module s4rf_rule_match (
  input  wire s4rf_pkg::rule_t [s4rf_pkg::NUM_RULES-1:0] rules,
  input  wire logic [7:0]                                cmd,
  input  wire logic [31:0]                               addr,
  output logic                                           granted
);
  import s4rf_pkg::*;

  logic [NUM_RULES-1:0] hit;
  logic [NUM_RULES-1:0] live;

  // Compare every rule in parallel; any hit is also the first hit
  for (genvar i = 0; i < NUM_RULES; i++) begin : g_rule
    logic [3:0] oct_ok;
    logic [7:0] want;

    assign want = rules[i].kind_bind ? CMD_BIND : CMD_CONNECT;

    for (genvar j = 0; j < 4; j++) begin : g_oct
      assign oct_ok[j] = rules[i].wild[j] ||
                         (rules[i].addr[8*(3-j) +: 8] == addr[8*(3-j) +: 8]);
    end

    assign live[i] = rules[i].valid;
    assign hit[i]  = rules[i].valid && (cmd == want) && (&oct_ok);
  end

  // An empty table lets everything through
  assign granted = (|hit) || !(|live);

endmodule

`default_nettype wire

/* src/socks4a_request_filter.sv */
// SOCKS4/4a request filter.
// Input channel (in_*): one request byte per beat, in_end_of_request on the
// last byte. Bytes are taken at one per cycle. Only a byte that ends a
// request can be held off, and only while the previous reply is still being
// sent and its last beat is not taken in the same cycle.
// Output channel (out_*): an eight-beat reply (0, 90/91, port, address) per
// CONNECT or BIND request of at least eight bytes, one beat per cycle while
// out_ready is high. The first beat is valid the cycle after the final
// request byte is accepted. Other commands and short requests give nothing.
// The rule check over all six rules is done in the same cycle as the final
// byte, so the reply register is the only stage between the two channels.
// Receiver stall: the current beat holds; request bytes keep flowing until
// the next request end arrives.
// Configuration (cfg_*): index 0 bind port, 1..6 permit rules; writes are
// always taken, higher indexes are dropped. Write only while idle.
// Reset (rst_n low, synchronous): request state, rules and bind port clear
// to zero, no reply is pending.
`default_nettype none

module socks4a_request_filter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request bytes
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_req_byte,
  input  wire logic                              in_end_of_request,
  // reply bytes
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_reply_byte,
  output logic                                   out_reply_final,
  output logic                                   out_granted,
  output logic                                   out_is_socks4a,
  output logic                                   out_is_bind,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [s4rf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [s4rf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import s4rf_pkg::*;

  // Configuration registers
  logic [15:0]                bind_port_r;
  rule_t [NUM_RULES-1:0]      rules_r;

  // Request state
  logic [POS_W-1:0]           pos_r,  pos_upd;
  logic [7:0]                 cmd_r,  cmd_upd;
  logic [15:0]                port_r, port_upd;
  logic [31:0]                addr_r, addr_upd;
  logic [1:0]                 nul_r,  nul_upd;

  // Reply register
  logic                       rep_valid_r, rep_valid_nxt;
  logic [BEAT_W-1:0]          beat_r,      beat_nxt;
  reply_t                     rep_r,       rep_nxt;

  logic                       in_take;
  logic                       out_take;
  logic                       out_last_take;
  logic                       reply_ok;
  logic                       granted;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_port_r <= '0;
    end else if (cfg_valid && cfg_index == CFG_BIND_PORT) begin
      bind_port_r <= cfg_data[15:0];
    end
  end

  for (genvar i = 0; i < NUM_RULES; i++) begin : g_rule_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rules_r[i] <= '0;
      end else if (cfg_valid && cfg_index == CFG_IDX_W'(CFG_RULE_BASE + i)) begin
        rules_r[i] <= rule_t'(cfg_data);
      end
    end
  end

  // Fold the incoming byte into the request state
  always_comb begin
    pos_upd  = pos_r;
    cmd_upd  = cmd_r;
    port_upd = port_r;
    addr_upd = addr_r;
    nul_upd  = nul_r;
    if (pos_r < POS_W'(MAX_REQUEST)) begin
      if (pos_r == POS_W'(1)) begin
        cmd_upd = in_req_byte;
      end else if (pos_r == POS_W'(2)) begin
        port_upd[15:8] = in_req_byte;
      end else if (pos_r == POS_W'(3)) begin
        port_upd[7:0] = in_req_byte;
      end else if (pos_r >= POS_W'(4) && pos_r < POS_W'(HEADER_LEN)) begin
        case (pos_r[1:0])
          2'd0:    addr_upd[31:24] = in_req_byte;
          2'd1:    addr_upd[23:16] = in_req_byte;
          2'd2:    addr_upd[15:8]  = in_req_byte;
          default: addr_upd[7:0]   = in_req_byte;
        endcase
      end else if (pos_r >= POS_W'(HEADER_LEN) && in_req_byte == 8'd0 &&
                   nul_r < 2'd2) begin
        nul_upd = nul_r + 2'd1;
      end
      pos_upd = pos_r + POS_W'(1);
    end
  end

  s4rf_rule_match u_match (
    .rules   (rules_r),
    .cmd     (cmd_upd),
    .addr    (addr_upd),
    .granted (granted)
  );

  assign reply_ok = in_end_of_request && (pos_upd >= POS_W'(HEADER_LEN)) &&
                    (cmd_upd == CMD_CONNECT || cmd_upd == CMD_BIND);

  // Handshakes: only a request end waits for the reply register
  assign out_take      = rep_valid_r && out_ready;
  assign out_last_take = out_take && (beat_r == BEAT_W'(REPLY_BEATS - 1));
  assign in_ready      = !rep_valid_r || out_last_take || !in_end_of_request;
  assign in_take       = in_valid && in_ready;

  // Advance request state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cmd_r  <= '0;
      port_r <= '0;
      addr_r <= '0;
      nul_r  <= '0;
    end else if (in_take) begin
      if (in_end_of_request) begin
        pos_r  <= '0;
        cmd_r  <= '0;
        port_r <= '0;
        addr_r <= '0;
        nul_r  <= '0;
      end else begin
        pos_r  <= pos_upd;
        cmd_r  <= cmd_upd;
        port_r <= port_upd;
        addr_r <= addr_upd;
        nul_r  <= nul_upd;
      end
    end
  end

  // Load a new reply or step through the current one
  always_comb begin
    rep_valid_nxt = rep_valid_r;
    beat_nxt      = beat_r;
    rep_nxt       = rep_r;
    if (in_take && reply_ok) begin
      rep_valid_nxt   = 1'b1;
      beat_nxt        = '0;
      rep_nxt.granted = granted;
      rep_nxt.is4a    = (nul_upd == 2'd2);
      rep_nxt.is_bind = (cmd_upd == CMD_BIND);
      rep_nxt.port    = (cmd_upd == CMD_BIND) ? bind_port_r : port_upd;
      rep_nxt.addr    = (cmd_upd == CMD_BIND) ? 32'd0 : addr_upd;
    end else if (out_last_take) begin
      rep_valid_nxt = 1'b0;
    end else if (out_take) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      rep_valid_r <= rep_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_r <= rep_nxt;
  end

  // Select the byte for the current beat
  always_comb begin
    case (beat_r)
      3'd0:    out_reply_byte = 8'd0;
      3'd1:    out_reply_byte = rep_r.granted ? REPLY_GRANT : REPLY_REJECT;
      3'd2:    out_reply_byte = rep_r.port[15:8];
      3'd3:    out_reply_byte = rep_r.port[7:0];
      3'd4:    out_reply_byte = rep_r.addr[31:24];
      3'd5:    out_reply_byte = rep_r.addr[23:16];
      3'd6:    out_reply_byte = rep_r.addr[15:8];
      default: out_reply_byte = rep_r.addr[7:0];
    endcase
  end

  assign out_valid       = rep_valid_r;
  assign out_reply_final = (beat_r == BEAT_W'(REPLY_BEATS - 1));
  assign out_granted     = rep_r.granted;
  assign out_is_socks4a  = rep_r.is4a;
  assign out_is_bind     = rep_r.is_bind;

endmodule

`default_nettype wire

/* src/s4rf_checker.sv */
`default_nettype none

module s4rf_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic                              in_end_of_request,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [7:0]                        out_reply_byte,
  input  wire logic                              out_reply_final,
  input  wire logic                              out_granted,
  input  wire logic                              out_is_socks4a,
  input  wire logic                              out_is_bind
);

  // A stalled reply beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_byte) &&
                               $stable(out_reply_final))
    else $error("reply beat changed while stalled");

  // A reply runs without gaps and keeps its flags until the final beat
  a_reply_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_reply_final |=>
      out_valid && $stable(out_granted) && $stable(out_is_bind) &&
      $stable(out_is_socks4a))
    else $error("reply broken off or flags changed mid reply");

  // Bytes inside a request are never held off
  a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_end_of_request |-> in_ready)
    else $error("mid-request byte stalled");

  // BIND replies end in a zero address
  a_bind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bind && out_reply_final |-> out_reply_byte == 8'd0)
    else $error("BIND reply carries a non-zero address");

endmodule

bind socks4a_request_filter s4rf_checker u_s4rf_checker (.*);

`default_nettype wire

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s4rf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 56;
  localparam int MAX_PRINTED   = 40;

  // Register index past the end of the map, and command codes outside the two served
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic [7:0]           CMD_NONE       = 8'h00;
  localparam logic [7:0]           CMD_ALL_ONES   = 8'hFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last_beat;
    logic       granted;
    logic       is4a;
    logic       is_bind;
  } reply_beat_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic [7:0]            in_req_byte       = 8'h00;
  logic                  in_end_of_request = 1'b0;
  logic                  out_ready         = 1'b1;
  logic                  cfg_valid         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [7:0]            out_reply_byte;
  logic                  out_reply_final;
  logic                  out_granted;
  logic                  out_is_socks4a;
  logic                  out_is_bind;
  logic                  cfg_ready;

  socks4a_request_filter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_byte       (in_req_byte),
    .in_end_of_request (in_end_of_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_byte    (out_reply_byte),
    .out_reply_final   (out_reply_final),
    .out_granted       (out_granted),
    .out_is_socks4a    (out_is_socks4a),
    .out_is_bind       (out_is_bind),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  // Filter state as predicted, and the reply beats still owed
  logic [POS_W-1:0] m_pos;
  logic [7:0]       m_cmd;
  logic [15:0]      m_port;
  logic [31:0]      m_addr;
  logic [1:0]       m_nuls;
  logic [15:0]      m_bind_port;
  rule_t            m_rules [NUM_RULES];

  reply_beat_t reply_beats_q[$];
  logic [7:0]  req_buf[$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  replies_due   = 0;
  int  rejects_due   = 0;
  int  socks4a_due   = 0;
  int  cfg_writes    = 0;
  int  beats_checked = 0;
  int  cycle_count   = 0;
  bit  idle_on       = 1'b1;
  bit  stall_on      = 1'b1;

  task automatic clear_request_state();
    m_pos  = '0;
    m_cmd  = '0;
    m_port = '0;
    m_addr = '0;
    m_nuls = '0;
  endtask

  task automatic reset_filter_state();
    m_bind_port = '0;
    for (int i = 0; i < NUM_RULES; i++) m_rules[i] = '0;
    clear_request_state();
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_BIND_PORT) begin
      m_bind_port = data[15:0];
    end else if (int'(idx) >= CFG_RULE_BASE && int'(idx) < CFG_RULE_BASE + NUM_RULES) begin
      m_rules[int'(idx) - CFG_RULE_BASE] = data;
    end
  endtask

  function automatic bit rule_hits(input rule_t r, input logic [7:0] cmd,
                                   input logic [31:0] addr);
    logic [7:0] want_cmd;
    want_cmd = r.kind_bind ? CMD_BIND : CMD_CONNECT;
    if (cmd != want_cmd) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!r.wild[i] && r.addr[24 - 8 * i +: 8] != addr[24 - 8 * i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First valid rule that matches grants; a table with no valid rule grants all
  function automatic bit access_permitted(input logic [7:0] cmd, input logic [31:0] addr);
    bit any_valid;
    any_valid = 1'b0;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (m_rules[i].valid) begin
        any_valid = 1'b1;
        if (rule_hits(m_rules[i], cmd, addr)) return 1'b1;
      end
    end
    return !any_valid;
  endfunction

  // Advance the predicted state by one request byte; queue the reply it closes
  task automatic predict_request_byte(input logic [7:0] b, input logic eor);
    int          p;
    bit          grant;
    logic [7:0]  octets [REPLY_BEATS];
    reply_beat_t beat;
    if (int'(m_pos) < MAX_REQUEST) begin
      p = int'(m_pos);
      if (p == 1) m_cmd = b;
      else if (p == 2) m_port[15:8] = b;
      else if (p == 3) m_port[7:0] = b;
      else if (p >= 4 && p < HEADER_LEN) m_addr = m_addr | (32'(b) << (8 * (7 - p)));
      else if (p >= HEADER_LEN && b == 8'h00 && m_nuls < 2) m_nuls = m_nuls + 2'd1;
      m_pos = m_pos + POS_W'(1);
    end
    if (eor) begin
      if (int'(m_pos) >= HEADER_LEN && (m_cmd == CMD_CONNECT || m_cmd == CMD_BIND)) begin
        grant     = access_permitted(m_cmd, m_addr);
        octets[0] = 8'h00;
        octets[1] = grant ? REPLY_GRANT : REPLY_REJECT;
        if (m_cmd == CMD_BIND) begin
          octets[2] = m_bind_port[15:8];
          octets[3] = m_bind_port[7:0];
          for (int k = 4; k < REPLY_BEATS; k++) octets[k] = 8'h00;
        end else begin
          octets[2] = m_port[15:8];
          octets[3] = m_port[7:0];
          octets[4] = m_addr[31:24];
          octets[5] = m_addr[23:16];
          octets[6] = m_addr[15:8];
          octets[7] = m_addr[7:0];
        end
        for (int k = 0; k < REPLY_BEATS; k++) begin
          beat.data      = octets[k];
          beat.last_beat = (k == REPLY_BEATS - 1);
          beat.granted   = grant;
          beat.is4a      = (m_nuls >= 2);
          beat.is_bind   = (m_cmd == CMD_BIND);
          reply_beats_q.push_back(beat);
        end
        replies_due++;
        if (!grant) rejects_due++;
        if (m_nuls >= 2) socks4a_due++;
      end
      clear_request_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < MAX_PRINTED)
      $display("%0t: reply beat %0d, %s: got 0x%02h, expected 0x%02h",
               $time, beats_checked, what, got, want);
    errors++;
  endtask

  // Compare each accepted reply beat with the oldest one owed
  always @(posedge clk) begin : check_reply_beat
    reply_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_beats_q.size() == 0) begin
        report_mismatch("unexpected beat", out_reply_byte, 8'h00);
      end else begin
        want = reply_beats_q.pop_front();
        if (out_reply_byte !== want.data)
          report_mismatch("reply_byte", out_reply_byte, want.data);
        if (out_reply_final !== want.last_beat)
          report_mismatch("reply_final", 8'(out_reply_final), 8'(want.last_beat));
        if (out_granted !== want.granted)
          report_mismatch("granted", 8'(out_granted), 8'(want.granted));
        if (out_is_socks4a !== want.is4a)
          report_mismatch("is_socks4a", 8'(out_is_socks4a), 8'(want.is4a));
        if (out_is_bind !== want.is_bind)
          report_mismatch("is_bind", 8'(out_is_bind), 8'(want.is_bind));
      end
      beats_checked++;
    end
  end

  // Stall the reply channel in bursts of random length
  initial begin : reply_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Give up after a generous number of cycles
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one request byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eor);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_req_byte       <= b;
    in_end_of_request <= eor;
    do @(posedge clk); while (!in_ready);
    predict_request_byte(b, eor);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the input idle until every owed beat is out, then let the block settle
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_request(input logic [7:0] cmd, input logic [15:0] port,
                               input logic [31:0] addr);
    req_buf.delete();
    req_buf.push_back(8'($urandom));
    req_buf.push_back(cmd);
    req_buf.push_back(port[15:8]);
    req_buf.push_back(port[7:0]);
    req_buf.push_back(addr[31:24]);
    req_buf.push_back(addr[23:16]);
    req_buf.push_back(addr[15:8]);
    req_buf.push_back(addr[7:0]);
  endtask

  // Append len non-NUL bytes, closed by a NUL if asked
  task automatic add_text(input int len, input bit terminate);
    repeat (len) req_buf.push_back(8'($urandom_range(1, 255)));
    if (terminate) req_buf.push_back(8'h00);
  endtask

  task automatic send_request();
    foreach (req_buf[i]) send_byte(req_buf[i], i == req_buf.size() - 1);
  endtask

  // Aim mostly at rule addresses, some exact and some one octet off
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    int          r;
    int          octet;
    r     = $urandom_range(0, 99);
    octet = $urandom_range(0, 3);
    if (r < 60) begin
      a = m_rules[$urandom_range(0, NUM_RULES - 1)].addr;
      if ($urandom_range(0, 3) == 0) a[8 * octet +: 8] = 8'($urandom);
    end else if (r < 65) begin
      a = '0;
    end else if (r < 70) begin
      a = '1;
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  task automatic random_request();
    int         r;
    logic [7:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      // well-formed CONNECT or BIND, 4 or 4a
      cmd = $urandom_range(0, 1) ? CMD_BIND : CMD_CONNECT;
      start_request(cmd, 16'($urandom), pick_address());
      add_text($urandom_range(0, 4), 1'b1);
      if ($urandom_range(0, 1)) add_text($urandom_range(0, 5), 1'b1);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) req_buf.push_back(8'h00);
          else req_buf.push_back(8'($urandom));
        end
      end
    end else if (r < 85) begin
      // cut short inside the header
      req_buf.delete();
      repeat ($urandom_range(1, HEADER_LEN - 1)) req_buf.push_back(8'($urandom));
    end else if (r < 93) begin
      // a command that is not served
      do cmd = 8'($urandom); while (cmd == CMD_CONNECT || cmd == CMD_BIND);
      start_request(cmd, 16'($urandom), $urandom);
      add_text($urandom_range(0, 4), 1'b1);
    end else begin
      // noise
      req_buf.delete();
      repeat ($urandom_range(1, 12)) req_buf.push_back(8'($urandom));
    end
    send_request();
  endtask

  task automatic load_random_rules(input int valid_pct);
    rule_t r;
    for (int i = 0; i < NUM_RULES; i++) begin
      r.valid     = ($urandom_range(0, 99) < valid_pct);
      r.kind_bind = 1'($urandom_range(0, 1));
      for (int k = 0; k < 4; k++) r.wild[k] = ($urandom_range(0, 3) == 0);
      r.addr      = $urandom;
      write_reg(CFG_IDX_W'(CFG_RULE_BASE + i), r);
    end
  endtask

  task automatic run_traffic_phase(input int n_bytes);
    int first;
    int pause_at;
    bit paused;
    first    = bytes_sent;
    pause_at = $urandom_range(n_bytes / 4, 3 * n_bytes / 4);
    paused   = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      // hold the sender once until the replies catch up
      if (!paused && bytes_sent - first >= pause_at) begin
        drain_replies();
        paused = 1'b1;
      end
      random_request();
    end
  endtask

  // Empty table after reset: grants, BIND port, 4a, short and unserved requests
  task automatic test_reset_defaults();
    start_request(CMD_CONNECT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request();
    start_request(CMD_BIND, 16'h0000, 32'h0000_0000);
    add_text(0, 1'b1);
    add_text(0, 1'b1);
    send_request();
    req_buf.delete();
    req_buf.push_back(8'h04);
    req_buf.push_back(CMD_CONNECT);
    req_buf.push_back(8'hFF);
    send_request();
    start_request(CMD_ALL_ONES, 16'h1234, 32'h0A00_0001);
    send_request();
    start_request(CMD_NONE, 16'h1234, 32'h0A00_0001);
    send_request();
  endtask

  // Exact rule, wildcard octet, near misses and a kind mismatch
  task automatic test_rule_table();
    drain_replies();
    write_reg(CFG_BIND_PORT, {22'($urandom), 16'hFFFF});
    write_reg(CFG_IDX_W'(CFG_RULE_BASE + 0), {1'b1, 1'b0, 4'b0000, 32'h0A01_0203});
    write_reg(CFG_IDX_W'(CFG_RULE_BASE + 1), {1'b1, 1'b1, 4'b0001, 32'h00C0_A801});
    for (int i = 2; i < NUM_RULES; i++) write_reg(CFG_IDX_W'(CFG_RULE_BASE + i), '0);
    // past the map: must change nothing
    write_reg(CFG_IDX_UNUSED, {1'b1, 1'b0, 4'b1111, 32'h0000_0000});
    start_request(CMD_CONNECT, 16'h0050, 32'h0A01_0203);
    send_request();
    start_request(CMD_CONNECT, 16'h0050, 32'h0A01_0204);
    send_request();
    start_request(CMD_BIND, 16'h0050, 32'h7FC0_A801);
    send_request();
    start_request(CMD_BIND, 16'h0050, 32'h7FC0_A802);
    send_request();
    start_request(CMD_CONNECT, 16'h0050, 32'h7FC0_A801);
    send_request();
  endtask

  // Run the byte counter into saturation; NULs past the limit must not count
  task automatic test_overlong_request();
    start_request(CMD_CONNECT, 16'h1F90, 32'h0A01_0203);
    while (req_buf.size() < MAX_REQUEST - 1) req_buf.push_back(8'h41);
    req_buf.push_back(8'h00);
    req_buf.push_back(8'h00);
    req_buf.push_back(8'h00);
    req_buf.push_back(8'h42);
    send_request();
    start_request(CMD_CONNECT, 16'h0001, 32'h0A01_0203);
    send_request();
  endtask

  // Random traffic over several table settings, the extremes among them
  task automatic test_random_traffic();
    rule_t r;
    drain_replies();
    write_reg(CFG_BIND_PORT, {22'($urandom), 16'($urandom)});
    load_random_rules(50);
    run_traffic_phase(PHASE_BYTES);

    // every rule valid, BIND, all octets wild
    drain_replies();
    write_reg(CFG_BIND_PORT, '1);
    for (int i = 0; i < NUM_RULES; i++) write_reg(CFG_IDX_W'(CFG_RULE_BASE + i), '1);
    run_traffic_phase(PHASE_BYTES);

    // all rules invalid but full of junk: the table counts as empty
    drain_replies();
    write_reg(CFG_BIND_PORT, {22'h3F_FFFF, 16'h0000});
    r       = '1;
    r.valid = 1'b0;
    for (int i = 0; i < NUM_RULES; i++) write_reg(CFG_IDX_W'(CFG_RULE_BASE + i), r);
    run_traffic_phase(PHASE_BYTES);

    drain_replies();
    write_reg(CFG_BIND_PORT, {22'($urandom), 16'($urandom)});
    load_random_rules(90);
    write_reg(CFG_IDX_UNUSED, {6'($urandom), 32'($urandom)});
    run_traffic_phase(PHASE_BYTES);

    // last stretch at full rate on both sides
    drain_replies();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_reg(CFG_BIND_PORT, {22'($urandom), 16'($urandom)});
    load_random_rules(60);
    run_traffic_phase(PHASE_BYTES);
  endtask

  initial begin
    reset_filter_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_rule_table();
    test_overlong_request();
    test_random_traffic();

    drain_replies();
    $display("Run covered %0d request bytes and %0d replies (%0d rejected, %0d SOCKS4a)",
             bytes_sent, replies_due, rejects_due, socks4a_due);
    $display("%0d register writes, %0d reply beats checked, %0d mismatches",
             cfg_writes, beats_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
